>>> hw/rtl/xalu_pkg.sv
// xalu_pkg: shared types and constants of the x86 integer alu with flags
// used by the channel interfaces, the core and the top level; no dependencies

package xalu_pkg;

   // field widths
   localparam int CMD_W   = 5;
   localparam int WIDTH_W = 2;
   localparam int DATA_W  = 32;
   localparam int COND_W  = 4;
   localparam int FLAGS_W = 4;

   // flag bit positions
   localparam int FLAG_CF = 0;
   localparam int FLAG_ZF = 1;
   localparam int FLAG_SF = 2;
   localparam int FLAG_OF = 3;

   // operation codes
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD  = 5'd0,
      CMD_OR   = 5'd1,
      CMD_ADC  = 5'd2,
      CMD_SBB  = 5'd3,
      CMD_AND  = 5'd4,
      CMD_SUB  = 5'd5,
      CMD_XOR  = 5'd6,
      CMD_CMP  = 5'd7,
      CMD_TEST = 5'd8,
      CMD_INC  = 5'd9,
      CMD_DEC  = 5'd10,
      CMD_NEG  = 5'd11,
      CMD_ROL  = 5'd12,
      CMD_ROR  = 5'd13,
      CMD_SHL  = 5'd14,
      CMD_SHR  = 5'd15,
      CMD_SAR  = 5'd16,
      CMD_COND = 5'd17
   } xalu_cmd_type;

   // operand widths; the unused code behaves as dword
   typedef enum logic [WIDTH_W-1:0] {
      WIDTH_BYTE  = 2'd0,
      WIDTH_WORD  = 2'd1,
      WIDTH_DWORD = 2'd2
   } xalu_width_type;

   // condition families, selected by the upper three bits of the condition nibble
   typedef enum logic [2:0] {
      COND_O  = 3'd0,
      COND_B  = 3'd1,
      COND_Z  = 3'd2,
      COND_BE = 3'd3,
      COND_S  = 3'd4,
      COND_P  = 3'd5,
      COND_L  = 3'd6,
      COND_LE = 3'd7
   } xalu_cond_type;

   // one request
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [WIDTH_W-1:0] width_code;
      logic [DATA_W-1:0]  lhs_operand;
      logic [DATA_W-1:0]  rhs_operand;
      logic [COND_W-1:0]  cond_code;
   } xalu_req_type;

   // one result
   typedef struct packed {
      logic [DATA_W-1:0]  alu_result;
      logic               write_back;
      logic [FLAGS_W-1:0] flags_out;
      logic               cond_true;
   } xalu_rsp_type;

endpackage

>>> hw/rtl/xalu_if.sv
// xalu_if: valid/ready channel interfaces for requests and results
// depends on xalu_pkg for the field widths

interface xalu_req_if;
   logic                            valid;
   logic                            ready;
   logic [xalu_pkg::CMD_W-1:0]      cmd;
   logic [xalu_pkg::WIDTH_W-1:0]    width_code;
   logic [xalu_pkg::DATA_W-1:0]     lhs_operand;
   logic [xalu_pkg::DATA_W-1:0]     rhs_operand;
   logic [xalu_pkg::COND_W-1:0]     cond_code;

   modport source (output valid, output cmd, output width_code, output lhs_operand,
                   output rhs_operand, output cond_code, input ready);
   modport sink   (input valid, input cmd, input width_code, input lhs_operand,
                   input rhs_operand, input cond_code, output ready);
endinterface

interface xalu_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [xalu_pkg::DATA_W-1:0]     alu_result;
   logic                            write_back;
   logic [xalu_pkg::FLAGS_W-1:0]    flags_out;
   logic                            cond_true;

   modport source (output valid, output alu_result, output write_back,
                   output flags_out, output cond_true, input ready);
   modport sink   (input valid, input alu_result, input write_back,
                   input flags_out, input cond_true, output ready);
endinterface

>>> hw/rtl/xalu_core.sv
// xalu_core: single-pass datapath that computes one result and the next flags
// depends on xalu_pkg for the request/result types and operation codes

module xalu_core (
   input  xalu_pkg::xalu_req_type           req_data,
   input  logic [xalu_pkg::FLAGS_W-1:0]     flags_cur,
   output xalu_pkg::xalu_rsp_type           rsp_data,
   output logic [xalu_pkg::FLAGS_W-1:0]     flags_next
);

   // zero and sign flags of a masked value
   function automatic logic [xalu_pkg::FLAGS_W-1:0] zs_flags(input logic [31:0] val,
                                                               input logic [31:0] sgn);
      logic [xalu_pkg::FLAGS_W-1:0] fl;
      begin
         fl = '0;
         fl[xalu_pkg::FLAG_ZF] = (val == 32'd0);
         fl[xalu_pkg::FLAG_SF] = |(val & sgn);
         return fl;
      end
   endfunction

   logic [31:0] mask;
   logic [31:0] sign;
   logic [31:0] rep;
   logic [31:0] a_val;
   logic [31:0] b_val;
   logic [4:0]  cnt;
   logic [4:0]  cnt_m1;
   logic        cin;
   logic        cf_cur;
   logic        zf_cur;
   logic        sf_cur;
   logic        of_cur;
   logic        base;
   logic        ct;

   logic [31:0] addend;
   logic        add_cin;
   logic [32:0] sum33;
   logic [31:0] add_r;
   logic        add_carry;
   logic        add_of;

   logic [31:0] sub_x;
   logic [31:0] sub_y;
   logic        sub_cin;
   logic [32:0] diff33;
   logic [31:0] sub_r;
   logic        sub_borrow;
   logic        sub_of;

   logic [31:0] logic_r;
   logic [63:0] rol64;
   logic [63:0] ror64;
   logic [63:0] shl64;
   logic [31:0] shl_r;
   logic        shl_c;
   logic [63:0] sx64;
   logic [63:0] shr64;
   logic [31:0] shr_r;
   logic        shr_c;
   logic [31:0] sh_r;
   logic        sh_c;
   logic        sh_of;

   logic [31:0] res;
   logic        wb;
   logic [xalu_pkg::FLAGS_W-1:0] nf;

   // width decode: value mask, sign bit and replicated operand for rotates
   always_comb begin
      case (req_data.width_code)
         xalu_pkg::WIDTH_BYTE: begin
            mask = 32'h0000_00ff;
            sign = 32'h0000_0080;
            rep  = {4{req_data.lhs_operand[7:0]}};
         end
         xalu_pkg::WIDTH_WORD: begin
            mask = 32'h0000_ffff;
            sign = 32'h0000_8000;
            rep  = {2{req_data.lhs_operand[15:0]}};
         end
         default: begin
            mask = 32'hffff_ffff;
            sign = 32'h8000_0000;
            rep  = req_data.lhs_operand;
         end
      endcase
   end

   assign a_val  = req_data.lhs_operand & mask;
   assign b_val  = req_data.rhs_operand & mask;
   assign cnt    = req_data.rhs_operand[4:0];
   assign cnt_m1 = cnt - 5'd1;
   assign cf_cur = flags_cur[xalu_pkg::FLAG_CF];
   assign zf_cur = flags_cur[xalu_pkg::FLAG_ZF];
   assign sf_cur = flags_cur[xalu_pkg::FLAG_SF];
   assign of_cur = flags_cur[xalu_pkg::FLAG_OF];
   assign cin    = cf_cur;

   // condition evaluation against the flags held before this request
   always_comb begin
      case (req_data.cond_code[3:1])
         xalu_pkg::COND_O:  base = of_cur;
         xalu_pkg::COND_B:  base = cf_cur;
         xalu_pkg::COND_Z:  base = zf_cur;
         xalu_pkg::COND_BE: base = cf_cur | zf_cur;
         xalu_pkg::COND_S:  base = sf_cur;
         xalu_pkg::COND_P:  base = 1'b0;
         xalu_pkg::COND_L:  base = sf_cur ^ of_cur;
         xalu_pkg::COND_LE: base = zf_cur | (sf_cur ^ of_cur);
         default:           base = 1'b0;
      endcase
      ct = req_data.cond_code[0] ? ~base : base;
   end

   // add, adc, inc
   always_comb begin
      addend    = (req_data.cmd == xalu_pkg::CMD_INC) ? 32'd1 : b_val;
      add_cin   = (req_data.cmd == xalu_pkg::CMD_ADC) ? cin : 1'b0;
      sum33     = {1'b0, a_val} + {1'b0, addend} + {32'd0, add_cin};
      add_r     = sum33[31:0] & mask;
      add_carry = |(sum33 & ~{1'b0, mask});
      add_of    = |(~(a_val ^ addend) & (a_val ^ add_r) & sign);
   end

   // sub, sbb, cmp, dec, neg
   always_comb begin
      sub_x = (req_data.cmd == xalu_pkg::CMD_NEG) ? 32'd0 : a_val;
      if (req_data.cmd == xalu_pkg::CMD_NEG) begin
         sub_y = a_val;
      end else if (req_data.cmd == xalu_pkg::CMD_DEC) begin
         sub_y = 32'd1;
      end else begin
         sub_y = b_val;
      end
      sub_cin    = (req_data.cmd == xalu_pkg::CMD_SBB) ? cin : 1'b0;
      diff33     = {1'b0, sub_x} - {1'b0, sub_y} - {32'd0, sub_cin};
      sub_r      = diff33[31:0] & mask;
      sub_borrow = diff33[32];
      sub_of     = |((sub_x ^ sub_y) & (sub_x ^ sub_r) & sign);
   end

   // bitwise logic
   always_comb begin
      case (req_data.cmd)
         xalu_pkg::CMD_OR:  logic_r = a_val | b_val;
         xalu_pkg::CMD_XOR: logic_r = a_val ^ b_val;
         default:           logic_r = a_val & b_val;
      endcase
   end

   // rotates work on the operand replicated across the word
   assign rol64 = {rep, rep} << cnt;
   assign ror64 = {rep, rep} >> cnt;

   // left shift with the carry taken from the first bit above the width
   always_comb begin
      shl64 = {32'd0, a_val} << cnt;
      shl_r = shl64[31:0] & mask;
      case (req_data.width_code)
         xalu_pkg::WIDTH_BYTE: shl_c = shl64[8];
         xalu_pkg::WIDTH_WORD: shl_c = shl64[16];
         default:              shl_c = shl64[32];
      endcase
   end

   // right shifts: shift by count minus one, last bit out is the carry
   always_comb begin
      sx64 = {32'd0, a_val};
      if ((req_data.cmd == xalu_pkg::CMD_SAR) && (|(a_val & sign))) begin
         sx64 = sx64 | ~{32'd0, mask};
      end
      shr64 = sx64 >> cnt_m1;
      shr_r = shr64[32:1] & mask;
      shr_c = shr64[0];
   end

   // shift result, carry and single-bit overflow
   always_comb begin
      if (req_data.cmd == xalu_pkg::CMD_SHL) begin
         sh_r = shl_r;
         sh_c = shl_c;
      end else begin
         sh_r = shr_r;
         sh_c = shr_c;
      end
      if (cnt != 5'd1) begin
         sh_of = of_cur;
      end else if (req_data.cmd == xalu_pkg::CMD_SHL) begin
         sh_of = (|(shl_r & sign)) ^ shl_c;
      end else if (req_data.cmd == xalu_pkg::CMD_SHR) begin
         sh_of = |(a_val & sign);
      end else begin
         sh_of = 1'b0;
      end
   end

   // result selection and flag update
   always_comb begin
      res = 32'd0;
      wb  = 1'b1;
      nf  = flags_cur;
      case (req_data.cmd)
         xalu_pkg::CMD_ADD, xalu_pkg::CMD_ADC, xalu_pkg::CMD_INC: begin
            res = add_r;
            nf  = zs_flags(add_r, sign);
            nf[xalu_pkg::FLAG_OF] = add_of;
            nf[xalu_pkg::FLAG_CF] = (req_data.cmd == xalu_pkg::CMD_INC) ? cf_cur : add_carry;
         end
         xalu_pkg::CMD_SUB, xalu_pkg::CMD_SBB, xalu_pkg::CMD_CMP, xalu_pkg::CMD_DEC,
         xalu_pkg::CMD_NEG: begin
            res = sub_r;
            nf  = zs_flags(sub_r, sign);
            nf[xalu_pkg::FLAG_OF] = sub_of;
            nf[xalu_pkg::FLAG_CF] = (req_data.cmd == xalu_pkg::CMD_DEC) ? cf_cur : sub_borrow;
            wb  = (req_data.cmd != xalu_pkg::CMD_CMP);
         end
         xalu_pkg::CMD_OR, xalu_pkg::CMD_AND, xalu_pkg::CMD_XOR, xalu_pkg::CMD_TEST: begin
            res = logic_r;
            nf  = zs_flags(logic_r, sign);
            wb  = (req_data.cmd != xalu_pkg::CMD_TEST);
         end
         xalu_pkg::CMD_ROL: begin
            res = rol64[63:32] & mask;
         end
         xalu_pkg::CMD_ROR: begin
            res = ror64[31:0] & mask;
         end
         xalu_pkg::CMD_SHL, xalu_pkg::CMD_SHR, xalu_pkg::CMD_SAR: begin
            if (cnt == 5'd0) begin
               res = a_val;
            end else begin
               res = sh_r;
               nf  = zs_flags(sh_r, sign);
               nf[xalu_pkg::FLAG_CF] = sh_c;
               nf[xalu_pkg::FLAG_OF] = sh_of;
            end
         end
         xalu_pkg::CMD_COND: begin
            res = {31'd0, ct};
            wb  = 1'b0;
         end
         default: begin
            res = 32'd0;
            wb  = 1'b0;
         end
      endcase
   end

   assign rsp_data.alu_result = res & mask;
   assign rsp_data.write_back = wb;
   assign rsp_data.flags_out  = nf;
   assign rsp_data.cond_true  = ct;
   assign flags_next          = nf;

endmodule

>>> hw/rtl/x86_alu_with_flags.sv
// Two-stage x86 integer alu: a request register, the single-pass core and a
// result register, with the CF/ZF/SF/OF flag register updated as each request
// leaves the request register. Every request gives exactly one result, which
// passes from the request register into the result register and is shown on
// the result port from there; a stalled result side holds it back. One request
// is taken per clock while the result side is not stalled, a rate set by the
// flag loop, which runs from the flag register through the core and back. While
// a stalled result waits, the request side stays ready only as long as the
// request register is empty. Depends on xalu_pkg, xalu_if and xalu_core.

module x86_alu_with_flags (
   input logic        clock,
   input logic        reset,
   xalu_req_if.sink   req_bus,
   xalu_rsp_if.source rsp_bus
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   xalu_pkg::xalu_req_type        in_data_ff;
   xalu_pkg::xalu_req_type        in_data_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   xalu_pkg::xalu_rsp_type        out_data_ff;
   xalu_pkg::xalu_rsp_type        out_data_in;
   logic [xalu_pkg::FLAGS_W-1:0]  flags_ff;
   logic [xalu_pkg::FLAGS_W-1:0]  flags_in;
   logic [xalu_pkg::FLAGS_W-1:0]  flags_next;
   xalu_pkg::xalu_rsp_type        core_rsp;
   logic                          advance;
   logic                          req_take;
   logic                          core_fire;
   xalu_pkg::xalu_req_type        req_payload;

   // gather the request payload
   assign req_payload.cmd         = req_bus.cmd;
   assign req_payload.width_code  = req_bus.width_code;
   assign req_payload.lhs_operand = req_bus.lhs_operand;
   assign req_payload.rhs_operand = req_bus.rhs_operand;
   assign req_payload.cond_code   = req_bus.cond_code;

   // handshake control
   assign advance       = ~out_valid_ff | rsp_bus.ready;
   assign req_bus.ready = ~in_valid_ff | advance;
   assign req_take      = req_bus.valid & req_bus.ready;
   assign core_fire     = in_valid_ff & advance;

   xalu_core u_core (
      .req_data   (in_data_ff),
      .flags_cur  (flags_ff),
      .rsp_data   (core_rsp),
      .flags_next (flags_next)
   );

   // next-state logic for the request register, result register and flags
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_data_in   = req_take ? req_payload : in_data_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      out_data_in  = core_fire ? core_rsp : out_data_ff;
      flags_in     = core_fire ? flags_next : flags_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   // result channel
   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.alu_result = out_data_ff.alu_result;
   assign rsp_bus.write_back = out_data_ff.write_back;
   assign rsp_bus.flags_out  = out_data_ff.flags_out;
   assign rsp_bus.cond_true  = out_data_ff.cond_true;

endmodule

>>> hw/rtl/xalu_checker.sv
// xalu_checker: port-level assertions for x86_alu_with_flags, bound to the top
// depends on x86_alu_with_flags and xalu_pkg for the field widths

module xalu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [xalu_pkg::DATA_W-1:0]        rsp_alu_result,
   input logic                               rsp_write_back,
   input logic [xalu_pkg::FLAGS_W-1:0]       rsp_flags_out,
   input logic                               rsp_cond_true
);

   logic [2:0] inflight_ff;
   logic [2:0] inflight_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid & req_ready;
   assign rsp_take = rsp_valid & rsp_ready;

   // requests accepted but not yet delivered
   always_comb begin
      inflight_in = inflight_ff + {2'd0, req_take} - {2'd0, rsp_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // reset empties the result register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alu_result)
         && $stable(rsp_write_back) && $stable(rsp_flags_out) && $stable(rsp_cond_true))
      else $error("stalled result changed");

   // no result without a request behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 3'd0)
      else $error("result shown with no request in flight");

   // two pipeline registers bound what is in flight
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd2)
      else $error("more requests in flight than the pipeline holds");

endmodule

bind x86_alu_with_flags xalu_checker u_xalu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_alu_result (rsp_bus.alu_result),
   .rsp_write_back (rsp_bus.write_back),
   .rsp_flags_out  (rsp_bus.flags_out),
   .rsp_cond_true  (rsp_bus.cond_true)
);
